/* sv/tps_pkg.sv */
`default_nettype none

package tps_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int DIST_BITS_DEF    = 16;
  localparam int LENGTH_BITS_DEF  = 32;

  localparam int MIN_VERTICES     = 3;
  localparam logic [4:0] VERTEX_COUNT_RESET = 5'd4;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_INIT    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

endpackage

`default_nettype wire

/* sv/tps_ram.sv */
`default_nettype none

module tps_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/tour_permutation_stepper.sv */
// Channel  | Direction | Handshake              | Payload
// in       | input     | in_valid / in_ready    | command, row_vertex, column_vertex,
//          |           |                        | pair_distance, tour_position
// out      | output    | out_valid / out_ready  | tour_length, advanced,
//          |           |                        | vertex_at_position, status
// cfg      | input     | cfg_valid / cfg_ready  | cfg_data (vertex_count)
//
// One command at a time; a sequencer works against a tour RAM and a distance RAM,
// each with one registered read port.
// Init: identity sweep of MAX_VERTICES tour slots, then a sum over the n tour edges.
// Advance: pivot scan from the tail, edge subtract, swap, suffix reversal, edge add.
// After rst (synchronous, active high) the tour RAM is swept to identity over all
// MAX_VERTICES positions before in_ready rises. A stalled result holds in the output
// register; the sequencer waits until it is taken.
`default_nettype none

module tour_permutation_stepper #(
  parameter int MAX_VERTICES = tps_pkg::MAX_VERTICES_DEF,
  parameter int DIST_BITS    = tps_pkg::DIST_BITS_DEF,
  parameter int LENGTH_BITS  = tps_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  row_vertex,
  input  wire logic [3:0]  column_vertex,
  input  wire logic [15:0] pair_distance,
  input  wire logic [3:0]  tour_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      tour_length,
  output logic             advanced,
  output logic [3:0]       vertex_at_position,
  output logic             status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);

  import tps_pkg::*;

  localparam int PW         = $clog2(MAX_VERTICES);
  localparam int NW         = $clog2(MAX_VERTICES + 1);
  localparam int EW         = NW + 1;
  localparam int PAIR_SLOTS = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int SW         = $clog2(PAIR_SLOTS);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CLEAR  = 5'd1;
  localparam logic [4:0] ST_RDV    = 5'd2;
  localparam logic [4:0] ST_SCAN_A = 5'd3;
  localparam logic [4:0] ST_SCAN_B = 5'd4;
  localparam logic [4:0] ST_SCAN_C = 5'd5;
  localparam logic [4:0] ST_FIND_A = 5'd6;
  localparam logic [4:0] ST_FIND_B = 5'd7;
  localparam logic [4:0] ST_ESEL   = 5'd8;
  localparam logic [4:0] ST_EA     = 5'd9;
  localparam logic [4:0] ST_EB     = 5'd10;
  localparam logic [4:0] ST_EC     = 5'd11;
  localparam logic [4:0] ST_ED     = 5'd12;
  localparam logic [4:0] ST_SWAP2  = 5'd13;
  localparam logic [4:0] ST_REV_A  = 5'd14;
  localparam logic [4:0] ST_REV_B  = 5'd15;
  localparam logic [4:0] ST_REV_C  = 5'd16;
  localparam logic [4:0] ST_REV_D  = 5'd17;
  localparam logic [4:0] ST_DONE   = 5'd18;

  localparam logic [1:0] PH_RESET = 2'd0;
  localparam logic [1:0] PH_INIT  = 2'd1;
  localparam logic [1:0] PH_SUB   = 2'd2;
  localparam logic [1:0] PH_ADD   = 2'd3;

  logic [4:0]             state;
  logic [1:0]             phase;
  logic [4:0]             vertex_count;
  logic [LENGTH_BITS-1:0] running_length;
  logic [LENGTH_BITS-1:0] sum;
  logic [NW-1:0]          p, s, lo, hi, k, ei, ej;
  logic [EW-1:0]          e;
  logic [PW-1:0]          va, right, pivot, sval;
  logic                   res_adv, res_status;
  logic [3:0]             res_vertex;

  logic [NW-1:0]          n;
  logic [PW-1:0]          t_raddr, t_waddr, t_wdata, tq;
  logic                   t_we;
  logic [SW-1:0]          d_raddr, d_waddr;
  logic [DIST_BITS-1:0]   d_wdata, dq;
  logic                   d_we;
  logic                   sel_en, sel_end;
  logic [NW-1:0]          sel_i, sel_j;
  logic                   bad_pair, pos_ok;
  logic [63:0]            len_wide, vtx_wide;
  logic [31:0]            dist_wide;

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW-1:0]   h, l;
    logic [2*PW-1:0] prod;
    h    = (a > b) ? a : b;
    l    = (a > b) ? b : a;
    prod = (2*PW)'(h) * (2*PW)'(h - PW'(1));
    return SW'(prod >> 1) + SW'(l);
  endfunction

  tps_ram #(.DEPTH(MAX_VERTICES), .WIDTH(PW)) u_tour (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(tq)
  );

  tps_ram #(.DEPTH(PAIR_SLOTS), .WIDTH(DIST_BITS)) u_dist (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(d_raddr),
    .rdata(dq)
  );

  always_comb begin
    if (int'(vertex_count) < MIN_VERTICES) begin
      n = NW'(MIN_VERTICES);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(vertex_count);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign bad_pair  = (row_vertex == column_vertex) || (int'(row_vertex) >= MAX_VERTICES) ||
                     (int'(column_vertex) >= MAX_VERTICES);
  assign pos_ok    = int'(tour_position) < MAX_VERTICES;
  assign len_wide  = 64'(running_length);
  assign vtx_wide  = 64'(tq);
  assign dist_wide = 32'(pair_distance);

  always_comb begin
    sel_en  = 1'b1;
    sel_end = 1'b0;
    sel_i   = '0;
    sel_j   = '0;
    if (phase == PH_INIT) begin
      sel_end = (e == EW'(n));
      sel_i   = e[NW-1:0];
      sel_j   = (e[NW-1:0] == n - NW'(1)) ? '0 : e[NW-1:0] + NW'(1);
    end else begin
      case (e)
        EW'(0): begin
          sel_i = p - NW'(2);
          sel_j = p - NW'(1);
        end
        EW'(1): begin
          sel_i = p - NW'(1);
          sel_j = p;
        end
        EW'(2): begin
          sel_en = (s != p);
          sel_i  = s - NW'(1);
          sel_j  = s;
        end
        EW'(3): begin
          sel_en = (s != n - NW'(1));
          sel_i  = s;
          sel_j  = s + NW'(1);
        end
        EW'(4): begin
          sel_i = '0;
          sel_j = n - NW'(1);
        end
        default: sel_end = 1'b1;
      endcase
    end
  end

  always_comb begin
    t_raddr = '0;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    d_raddr = slot_of(va, tq);
    d_we    = 1'b0;
    d_waddr = slot_of(PW'(row_vertex), PW'(column_vertex));
    d_wdata = dist_wide[DIST_BITS-1:0];
    unique case (state)
      ST_IDLE: begin
        t_raddr = PW'(tour_position);
        d_we    = in_valid && (command == CMD_WRITE) && !bad_pair;
      end
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = k[PW-1:0];
        t_wdata = k[PW-1:0];
      end
      ST_SCAN_A: t_raddr = p[PW-1:0];
      ST_SCAN_B: t_raddr = PW'(p - NW'(1));
      ST_SCAN_C: t_raddr = PW'(p - NW'(2));
      ST_FIND_A: t_raddr = s[PW-1:0];
      ST_FIND_B: t_raddr = PW'(s - NW'(1));
      ST_ESEL: begin
        t_we    = sel_end && (phase == PH_SUB);
        t_waddr = PW'(p - NW'(1));
        t_wdata = sval;
      end
      ST_EA: t_raddr = ei[PW-1:0];
      ST_EB: t_raddr = ej[PW-1:0];
      ST_SWAP2: begin
        t_we    = 1'b1;
        t_waddr = s[PW-1:0];
        t_wdata = pivot;
      end
      ST_REV_A: t_raddr = lo[PW-1:0];
      ST_REV_B: t_raddr = hi[PW-1:0];
      ST_REV_C: begin
        t_we    = 1'b1;
        t_waddr = lo[PW-1:0];
        t_wdata = tq;
      end
      ST_REV_D: begin
        t_we    = 1'b1;
        t_waddr = hi[PW-1:0];
        t_wdata = va;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      phase          <= PH_RESET;
      k              <= '0;
      vertex_count   <= VERTEX_COUNT_RESET;
      running_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            res_adv    <= 1'b0;
            res_status <= (command == CMD_WRITE) && bad_pair;
            res_vertex <= '0;
            unique case (command)
              CMD_WRITE: state <= ST_DONE;
              CMD_INIT: begin
                k     <= '0;
                phase <= PH_INIT;
                state <= ST_CLEAR;
              end
              CMD_ADVANCE: begin
                p     <= n - NW'(1);
                phase <= PH_SUB;
                state <= ST_SCAN_A;
              end
              CMD_READ: state <= pos_ok ? ST_RDV : ST_DONE;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          k <= k + NW'(1);
          if (k == NW'(MAX_VERTICES - 1)) begin
            e     <= '0;
            sum   <= '0;
            state <= (phase == PH_INIT) ? ST_ESEL : ST_IDLE;
          end
        end
        ST_RDV: begin
          res_vertex <= vtx_wide[3:0];
          state      <= ST_DONE;
        end
        ST_SCAN_A: state <= ST_SCAN_B;
        ST_SCAN_B: begin
          right <= tq;
          state <= ST_SCAN_C;
        end
        ST_SCAN_C: begin
          if (tq >= right) begin
            if (p <= NW'(2)) begin
              state <= ST_DONE;
            end else begin
              p     <= p - NW'(1);
              right <= tq;
            end
          end else begin
            pivot <= tq;
            s     <= n - NW'(1);
            state <= ST_FIND_A;
          end
        end
        ST_FIND_A: state <= ST_FIND_B;
        ST_FIND_B: begin
          if (tq <= pivot) begin
            s <= s - NW'(1);
          end else begin
            sval  <= tq;
            e     <= '0;
            sum   <= '0;
            state <= ST_ESEL;
          end
        end
        ST_ESEL: begin
          if (sel_end) begin
            unique case (phase)
              PH_SUB: begin
                running_length <= running_length - sum;
                state          <= ST_SWAP2;
              end
              PH_ADD: begin
                running_length <= running_length + sum;
                res_adv        <= 1'b1;
                state          <= ST_DONE;
              end
              default: begin
                running_length <= sum;
                state          <= ST_DONE;
              end
            endcase
          end else if (sel_en) begin
            ei    <= sel_i;
            ej    <= sel_j;
            state <= ST_EA;
          end else begin
            e <= e + EW'(1);
          end
        end
        ST_EA: state <= ST_EB;
        ST_EB: begin
          va    <= tq;
          state <= ST_EC;
        end
        ST_EC: state <= ST_ED;
        ST_ED: begin
          sum   <= sum + LENGTH_BITS'(dq);
          e     <= e + EW'(1);
          state <= ST_ESEL;
        end
        ST_SWAP2: begin
          lo    <= p;
          hi    <= n - NW'(1);
          state <= ST_REV_A;
        end
        ST_REV_A: begin
          if (lo < hi) begin
            state <= ST_REV_B;
          end else begin
            s     <= n - s + p - NW'(1);
            e     <= '0;
            sum   <= '0;
            phase <= PH_ADD;
            state <= ST_ESEL;
          end
        end
        ST_REV_B: begin
          va    <= tq;
          state <= ST_REV_C;
        end
        ST_REV_C: state <= ST_REV_D;
        ST_REV_D: begin
          lo    <= lo + NW'(1);
          hi    <= hi - NW'(1);
          state <= ST_REV_A;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      tour_length        <= len_wide[31:0];
      advanced           <= res_adv;
      vertex_at_position <= res_vertex;
      status             <= res_status;
    end
  end

endmodule

`default_nettype wire

/* sv/tps_checker.sv */
`default_nettype none

module tps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        advanced,
  input wire logic [3:0]  vertex_at_position,
  input wire logic        status
);

  import tps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(advanced && status))
    else $error("advanced and status both set");

  a_vertex_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (vertex_at_position != 4'd0) |-> !advanced && !status)
    else $error("vertex reported with other flags");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer while busy");

endmodule

bind tour_permutation_stepper tps_checker u_tps_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .advanced          (advanced),
  .vertex_at_position(vertex_at_position),
  .status            (status)
);

`default_nettype wire
